// ===== design/wnpgs_pkg.sv =====
`default_nettype none
package wnpgs_pkg;
   localparam int MaxGrid = 32;
   localparam int SitesPerCell = 8;
   localparam int CellBits = $clog2(MaxGrid);
   localparam int SlotBits = $clog2(SitesPerCell);
   localparam int NCells = MaxGrid * MaxGrid;
   localparam int NSites = NCells * SitesPerCell;
   localparam int CellAddrBits = 2 * CellBits;
   localparam int SiteAddrBits = CellAddrBits + SlotBits;

   localparam logic [1:0] OP_WRITE_SITE = 2'd0;
   localparam logic [1:0] OP_SET_COUNT = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [5:0] GRID_RESET = 6'd32;

   typedef struct packed {
      logic [1:0] opcode;
      logic [4:0] cell_x;
      logic [4:0] cell_y;
      logic [2:0] slot;
      logic [3:0] site_count;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [3:0] pos_z;
      logic [15:0] site_weight;
      logic signed [15:0] site_tree;
      logic [3:0] query_layer;
   } req_type;

   typedef struct packed {
      logic found;
      logic [4:0] best_cell_x;
      logic [4:0] best_cell_y;
      logic [2:0] best_slot;
      logic [15:0] best_weight;
      logic signed [15:0] best_tree;
      logic [3:0] result_layer;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic write_site;
      logic write_count;
      logic next_cell;
      logic read_count;
      logic issue;
      logic finish;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic cell_valid;
      logic cell_last;
      logic slot_last;
      logic drained;
      logic clear_last;
   } sts_type;
endpackage
`default_nettype wire

// ===== design/weighted_nearest_point_grid_search_core.sv =====
// Weighted nearest-site search over a grid of up to 32 by 32 cells.
// Input beats are taken on req_ when start is high and busy is low.
// Opcode 0 stores one site, opcode 1 sets a cell's site count, and both
// finish with no result, busy staying low. Opcode 2 queries the site of least
// power distance in the 3x3 cells around the point's cell.
// A query scans nine cell positions, up to 72 sites in all; for each it selects
// the cell, reads its site count, then reads the site memory one site a cycle.
// Once the pipeline has drained the result beat is given, and busy drops in the
// cycle after it; a new query is taken only when busy is low.
// One result beat per query appears on rsp_ for one cycle with rsp_valid;
// the receiver must take it, as there is no stall.
// grid_size is written through the csr_ APB port at address 0.
// After reset the block clears all 1024 cell counts with busy high and sets
// grid_size to 32; sites stay undefined until written.
`default_nettype none
module weighted_nearest_point_grid_search_core
   import wnpgs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [1:0] csr_paddr,
   input wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [5:0] grid_size_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {26'd0, grid_size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == 2'd0)) begin
         grid_size_ff <= csr_pwdata[5:0];
      end
   end

   wnpgs_control u_control (
      .clock(clock),
      .reset(reset),
      .start(start),
      .opcode(req_data.opcode),
      .sts(sts),
      .cmd(cmd),
      .busy(busy),
      .rsp_valid(rsp_valid)
   );

   wnpgs_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .req(req_data),
      .grid_size(grid_size_ff),
      .cmd(cmd),
      .sts(sts),
      .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

// ===== design/wnpgs_datapath.sv =====
`default_nettype none
module wnpgs_datapath
   import wnpgs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire req_type req,
   input wire logic [5:0] grid_size,
   input wire cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);
   logic [35:0] pos_mem [NSites];
   logic [31:0] attr_mem [NSites];
   logic [3:0] count_mem [NCells];
   logic [CellAddrBits-1:0] clr_ff;

   req_type req_ff;
   logic [5:0] size_ff;
   logic [CellBits-1:0] qx_ff, qy_ff;
   logic [1:0] di_ff, dj_ff;
   logic [CellBits-1:0] ci_ff, cj_ff;
   logic ci_ok_ff;
   logic [3:0] cnt_ff;
   logic [3:0] p_ff;

   logic [35:0] rd_pos_ff;
   logic [31:0] rd_attr_ff;
   logic s1_v_ff;
   logic [CellBits-1:0] s1_x_ff, s1_y_ff;
   logic [SlotBits-1:0] s1_s_ff;

   logic s2_v_ff;
   logic [33:0] sx_ff, sy_ff, sw_ff;
   logic [7:0] sz_ff;
   logic [CellBits-1:0] s2_x_ff, s2_y_ff;
   logic [SlotBits-1:0] s2_s_ff;
   logic [31:0] s2_attr_ff;

   logic signed [41:0] best_ff;
   logic found_ff;
   logic [CellBits-1:0] bx_ff, by_ff;
   logic [SlotBits-1:0] bs_ff;
   logic [31:0] battr_ff;

   logic [5:0] size_c;
   logic [21:0] mx, my;
   logic signed [6:0] ii, jj;
   logic cell_in_grid;
   logic [CellAddrBits-1:0] wcell, rcell;
   logic signed [16:0] dx, dy;
   logic signed [4:0] dz;
   logic signed [41:0] pw;

   assign size_c = (grid_size > 6'(MaxGrid)) ? 6'(MaxGrid) : grid_size;
   assign mx = 22'(req.pos_x) * 22'(size_c);
   assign my = 22'(req.pos_y) * 22'(size_c);
   assign ii = $signed({2'b0, qx_ff}) + $signed({5'b0, di_ff}) - 7'sd1;
   assign jj = $signed({2'b0, qy_ff}) + $signed({5'b0, dj_ff}) - 7'sd1;
   assign cell_in_grid = (ii >= 0) && (jj >= 0) && (ii < $signed({1'b0, size_ff}))
      && (jj < $signed({1'b0, size_ff}));
   assign wcell = {req.cell_y, req.cell_x};
   assign rcell = {cj_ff, ci_ff};

   always_ff @(posedge clock) begin
      if (cmd.write_site) begin
         pos_mem[{wcell, req.slot}] <= {req.pos_x, req.pos_y, req.pos_z};
         attr_mem[{wcell, req.slot}] <= {req.site_weight, req.site_tree};
      end
      if (cmd.clear) begin
         count_mem[clr_ff] <= 4'd0;
      end else if (cmd.write_count) begin
         count_mem[wcell] <= (req.site_count > 4'(SitesPerCell)) ?
            4'(SitesPerCell) : req.site_count;
      end
      if (cmd.issue) begin
         rd_pos_ff <= pos_mem[{rcell, p_ff[SlotBits-1:0]}];
         rd_attr_ff <= attr_mem[{rcell, p_ff[SlotBits-1:0]}];
      end
      if (cmd.read_count) begin
         cnt_ff <= ci_ok_ff ? count_mem[rcell] : 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + CellAddrBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         size_ff <= size_c;
         qx_ff <= mx[16 +: CellBits];
         qy_ff <= my[16 +: CellBits];
         di_ff <= 2'd0;
         dj_ff <= 2'd0;
         p_ff <= '0;
      end
      if (cmd.next_cell) begin
         ci_ff <= ii[CellBits-1:0];
         cj_ff <= jj[CellBits-1:0];
         ci_ok_ff <= cell_in_grid;
         p_ff <= '0;
         if (di_ff == 2'd2) begin
            di_ff <= 2'd0;
            dj_ff <= dj_ff + 2'd1;
         end else begin
            di_ff <= di_ff + 2'd1;
         end
      end
      if (cmd.issue) begin
         p_ff <= p_ff + 4'd1;
         s1_x_ff <= ci_ff;
         s1_y_ff <= cj_ff;
         s1_s_ff <= p_ff[SlotBits-1:0];
      end
      s2_x_ff <= s1_x_ff;
      s2_y_ff <= s1_y_ff;
      s2_s_ff <= s1_s_ff;
      s2_attr_ff <= rd_attr_ff;
      sx_ff <= 34'(dx) * 34'(dx);
      sy_ff <= 34'(dy) * 34'(dy);
      sz_ff <= 8'(dz) * 8'(dz);
      sw_ff <= 34'(rd_attr_ff[31:16]) * 34'(rd_attr_ff[31:16]);
   end

   assign dx = $signed({1'b0, req_ff.pos_x}) - $signed({1'b0, rd_pos_ff[35:20]});
   assign dy = $signed({1'b0, req_ff.pos_y}) - $signed({1'b0, rd_pos_ff[19:4]});
   assign dz = $signed({1'b0, req_ff.pos_z}) - $signed({1'b0, rd_pos_ff[3:0]});
   assign pw = $signed({8'b0, sx_ff}) + $signed({8'b0, sy_ff})
      + $signed({2'b0, sz_ff, 32'b0}) - $signed({8'b0, sw_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.issue;
         s2_v_ff <= s1_v_ff;
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (s2_v_ff && (pw < best_ff)) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         best_ff <= 42'sd10 <<< 32;
      end else if (s2_v_ff && (pw < best_ff)) begin
         best_ff <= pw;
         bx_ff <= s2_x_ff;
         by_ff <= s2_y_ff;
         bs_ff <= s2_s_ff;
         battr_ff <= s2_attr_ff;
      end
   end

   assign sts.is_query = (req_ff.opcode == OP_QUERY);
   assign sts.cell_valid = ci_ok_ff;
   assign sts.cell_last = (di_ff == 2'd0) && (dj_ff == 2'd3);
   assign sts.slot_last = (p_ff >= cnt_ff);
   assign sts.drained = !s1_v_ff && !s2_v_ff;
   assign sts.clear_last = &clr_ff;

   always_comb begin
      rsp_data.found = found_ff;
      rsp_data.best_cell_x = found_ff ? bx_ff : 5'd0;
      rsp_data.best_cell_y = found_ff ? by_ff : 5'd0;
      rsp_data.best_slot = found_ff ? bs_ff : 3'd0;
      rsp_data.best_weight = found_ff ? battr_ff[31:16] : 16'd0;
      rsp_data.best_tree = found_ff ? battr_ff[15:0] : 16'hFFFF;
      rsp_data.result_layer = req_ff.query_layer;
   end
endmodule
`default_nettype wire

// ===== design/wnpgs_control.sv =====
`default_nettype none
module wnpgs_control
   import wnpgs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [1:0] opcode,
   input wire sts_type sts,
   output cmd_type cmd,
   output logic busy,
   output logic rsp_valid
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CELL = 3'd1;
   localparam logic [2:0] S_COUNT = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;
   localparam logic [2:0] S_CLEAR = 3'd6;

   logic [2:0] state_ff, state_in;
   logic go;

   assign go = start && (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      cmd.load = go;
      cmd.write_site = go && (opcode == OP_WRITE_SITE);
      cmd.write_count = go && (opcode == OP_SET_COUNT);
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (go && (opcode == OP_QUERY)) begin
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            if (sts.cell_last) begin
               state_in = S_DRAIN;
            end else begin
               cmd.next_cell = 1'b1;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.read_count = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.slot_last) begin
               state_in = S_CELL;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         S_DRAIN: begin
            if (sts.drained) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/wnpgs_checker.sv =====
`default_nettype none
module wnpgs_checker
   import wnpgs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire req_type req_data,
   input wire logic rsp_valid,
   input wire rsp_type rsp_data
);
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat repeated");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");
   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.opcode != OP_QUERY)) |=> !busy)
      else $error("write beat held the block");
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.opcode == OP_QUERY)) |=> busy)
      else $error("query not started");
   a_notfound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.best_tree == -16'sd1))
      else $error("empty result has a tree index");
endmodule

bind weighted_nearest_point_grid_search_core wnpgs_checker u_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_data(rsp_data)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
   import wnpgs_pkg::*;

   class site_search_board;
      logic [15:0] xs [NSites];
      logic [15:0] ys [NSites];
      logic [3:0] zs [NSites];
      logic [15:0] ws [NSites];
      logic [15:0] trees [NSites];
      logic [3:0] counts [NCells];
      logic [5:0] grid_size;
      rsp_type pending_results[$];
      int errors;

      function void clear();
         foreach (counts[k]) counts[k] = 0;
         grid_size = GRID_RESET;
         errors = 0;
      endfunction

      function rsp_type search(req_type r);
         rsp_type o;
         longint size, qx, qy, best, dx, dy, dz, sw, pw;
         int c, a;
         size = (grid_size > MaxGrid) ? MaxGrid : grid_size;
         qx = (longint'(r.pos_x) * size) >>> 16;
         qy = (longint'(r.pos_y) * size) >>> 16;
         best = longint'(10) <<< 32;
         o = '0;
         o.best_tree = 16'hFFFF;
         o.result_layer = r.query_layer;
         for (longint j = qy - 1; j <= qy + 1; j++) begin
            for (longint i = qx - 1; i <= qx + 1; i++) begin
               if (i < 0 || i >= size || j < 0 || j >= size) continue;
               c = int'(j) * MaxGrid + int'(i);
               for (int p = 0; p < counts[c]; p++) begin
                  a = c * SitesPerCell + p;
                  dx = longint'(r.pos_x) - longint'(xs[a]);
                  dy = longint'(r.pos_y) - longint'(ys[a]);
                  dz = (longint'(r.pos_z) - longint'(zs[a])) * 65536;
                  sw = longint'(ws[a]);
                  pw = dx * dx + dy * dy + dz * dz - sw * sw;
                  if (pw < best) begin
                     best = pw;
                     o.found = 1'b1;
                     o.best_cell_x = i[4:0];
                     o.best_cell_y = j[4:0];
                     o.best_slot = p[2:0];
                     o.best_weight = ws[a];
                     o.best_tree = trees[a];
                  end
               end
            end
         end
         return o;
      endfunction

      function void note_beat(req_type r);
         int a;
         case (r.opcode)
            OP_WRITE_SITE: begin
               a = (int'(r.cell_y) * MaxGrid + int'(r.cell_x)) * SitesPerCell + int'(r.slot);
               xs[a] = r.pos_x;
               ys[a] = r.pos_y;
               zs[a] = r.pos_z;
               ws[a] = r.site_weight;
               trees[a] = r.site_tree;
            end
            OP_SET_COUNT: begin
               counts[int'(r.cell_y) * MaxGrid + int'(r.cell_x)] =
                  (r.site_count > SitesPerCell) ? 4'(SitesPerCell) : r.site_count;
            end
            OP_QUERY: pending_results = {pending_results, search(r)};
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            $display("   found %b/%b cell %0d,%0d/%0d,%0d slot %0d/%0d", want.found,
                     got.found, want.best_cell_x, want.best_cell_y, got.best_cell_x,
                     got.best_cell_y, want.best_slot, got.best_slot);
            $display("   weight %h/%h tree %h/%h layer %0d/%0d", want.best_weight,
                     got.best_weight, want.best_tree, got.best_tree,
                     want.result_layer, got.result_layer);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   site_search_board board;
   bit written [NSites];
   int idle_pct;
   int eff_size;

   weighted_nearest_point_grid_search_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_psel(csr_psel),
      .csr_penable(csr_penable), .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_data);
   end

   initial begin
      #40_000_000;
      $display("tb_top failed");
      $finish;
   end

   task automatic send(req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      board.note_beat(r);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (board.pending_results.size() != 0 || busy);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_grid(logic [5:0] v);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= {$urandom} & 32'hFFFF_FFC0 | 32'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[5:0] !== v) begin
         $display("%0t: grid_size readback expected %h actual %h", $time, v, csr_prdata[5:0]);
         board.errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      board.grid_size = v;
      eff_size = (v > MaxGrid) ? MaxGrid : v;
      @(posedge clock);
   endtask

   task automatic put_site(int cx, int cy, int s, logic [15:0] x, logic [15:0] y,
                           logic [3:0] z, logic [15:0] w, logic [15:0] t);
      req_type r;
      r = '0;
      r.opcode = OP_WRITE_SITE;
      r.cell_x = cx[4:0];
      r.cell_y = cy[4:0];
      r.slot = s[2:0];
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.site_weight = w;
      r.site_tree = t;
      r.site_count = 4'($urandom);
      r.query_layer = 4'($urandom);
      written[(cy * MaxGrid + cx) * SitesPerCell + s] = 1'b1;
      send(r);
   endtask

   function automatic logic [15:0] near_coord(int c);
      int sz, v;
      sz = (eff_size == 0) ? MaxGrid : eff_size;
      v = (c * 65536) / sz + $urandom_range(0, 65535 / sz);
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic random_site(int cx, int cy, int s);
      logic [3:0] z;
      z = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
      put_site(cx, cy, s, near_coord(cx), near_coord(cy), z, 16'($urandom),
               ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom));
   endtask

   task automatic put_count(int cx, int cy, int n);
      req_type r;
      int lim;
      lim = (n > SitesPerCell) ? SitesPerCell : n;
      for (int s = 0; s < lim; s++)
         if (!written[(cy * MaxGrid + cx) * SitesPerCell + s]) random_site(cx, cy, s);
      r = req_type'({$urandom, $urandom, $urandom, $urandom});
      r.opcode = OP_SET_COUNT;
      r.cell_x = cx[4:0];
      r.cell_y = cy[4:0];
      r.site_count = n[3:0];
      send(r);
   endtask

   task automatic query(logic [15:0] x, logic [15:0] y, logic [3:0] z, logic [3:0] layer);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom, $urandom});
      r.opcode = OP_QUERY;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.query_layer = layer;
      send(r);
   endtask

   task automatic random_beat();
      req_type r;
      int pick, cx, cy, hi;
      pick = $urandom_range(0, 99);
      hi = (eff_size == 0 || $urandom_range(0, 9) == 0) ? MaxGrid - 1 : eff_size - 1;
      cx = $urandom_range(0, hi);
      cy = $urandom_range(0, hi);
      if (pick < 25) begin
         random_site(cx, cy, $urandom_range(0, SitesPerCell - 1));
      end else if (pick < 40) begin
         put_count(cx, cy, ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                         : $urandom_range(0, 8));
      end else if (pick < 44) begin
         r = req_type'({$urandom, $urandom, $urandom, $urandom});
         r.opcode = 2'b11;
         send(r);
      end else begin
         query(($urandom_range(0, 3) == 0) ? 16'($urandom) : near_coord(cx),
               ($urandom_range(0, 3) == 0) ? 16'($urandom) : near_coord(cy),
               ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2)),
               4'($urandom));
      end
   endtask

   initial begin
      logic [5:0] sizes [8] = '{6'd32, 6'd1, 6'd3, 6'd63, 6'd0, 6'd7, 6'd16, 6'd32};
      int pcts [8] = '{0, 57, 9, 0, 57, 9, 0, 57};
      board = new();
      board.clear();
      eff_size = MaxGrid;
      idle_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      put_site(0, 0, 0, 16'h0000, 16'h0000, 4'd0, 16'hFFFF, 16'h7FFF);
      put_site(0, 0, 1, 16'h0000, 16'h0000, 4'd0, 16'hFFFF, 16'h0001);
      put_site(0, 0, 2, 16'h0100, 16'h0100, 4'd15, 16'h0000, 16'hFFFF);
      put_count(0, 0, 15);
      put_site(31, 31, 0, 16'hFFFF, 16'hFFFF, 4'd15, 16'h0000, 16'hFFFF);
      put_count(31, 31, 1);
      put_site(30, 31, 0, 16'hF000, 16'hFFFF, 4'd11, 16'h8000, 16'h1234);
      put_count(30, 31, 1);
      query(16'h0000, 16'h0000, 4'd0, 4'd15);
      query(16'hFFFF, 16'hFFFF, 4'd15, 4'd0);
      query(16'hFFFF, 16'hFFFF, 4'd0, 4'd5);
      query(16'h8000, 16'h8000, 4'd0, 4'd9);
      query(16'h0800, 16'h0000, 4'd4, 4'd3);
      send(req_type'({2'b11, 74'h3FF_FFFF_FFFF_FFFF_FFFF}));
      put_count(0, 0, 0);
      query(16'h0000, 16'h0000, 4'd0, 4'd1);

      for (int ph = 0; ph < 8; ph++) begin
         idle_pct = pcts[ph];
         set_grid(sizes[ph]);
         if (ph == 1) query(16'h0000, 16'h0000, 4'd0, 4'd2);
         for (int k = 0; k < 80; k++) random_beat();
      end

      drain();
      if (board.pending_results.size() != 0) board.errors++;
      if (board.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
design/wnpgs_pkg.sv
design/wnpgs_datapath.sv
design/wnpgs_control.sv
design/weighted_nearest_point_grid_search_core.sv
design/wnpgs_checker.sv
tb/sv/tb_top.sv
